FILE: rtl/pngcrc_pkg.sv
package pngcrc_pkg;

  // register indexes of the configuration port
  localparam logic REG_INPUT_LENGTH = 1'b0;
  localparam logic REG_OUTPUT_LIMIT = 1'b1;

  // chunk parser phases
  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;
  localparam logic [2:0] PH_STOP = 3'd5;

  localparam logic MODE_REWRITE = 1'b0;
  localparam logic MODE_PASS    = 1'b1;

  localparam logic [31:0] IEND_WORD      = 32'h4945_4E44;
  localparam logic [33:0] CHUNK_OVERHEAD = 34'd12;
  localparam logic [31:0] MIN_FILE_LEN   = 32'd8;
  localparam logic [31:0] SIG_LEN        = 32'd8;
  localparam logic [31:0] FIELD_LEN      = 32'd4;
  localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;

  // command queue between parser and output side
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic        has_byte;
    logic        has_len;
    logic [31:0] data;
    logic        has_end;
    logic [31:0] end_len;
    logic        rebuilt;
  } cmd_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      3'd7:    v = 8'h0A;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/pngcrc_front.sv
module pngcrc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         in_byte_i,
  input  logic [31:0]        input_length_i,
  input  logic [31:0]        output_limit_i,
  input  logic               q_full_i,
  output logic               q_wr_o,
  output pngcrc_pkg::cmd_t   q_wdata_o
);
  import pngcrc_pkg::*;

  logic [31:0] pos_q, pos_d;
  logic [2:0]  phase_q, phase_d;
  logic        mode_q, mode_d;
  logic [31:0] clen_q, clen_d;
  logic [31:0] fcnt_q, fcnt_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] twin_q, twin_d;
  logic [31:0] ecnt_q, ecnt_d;

  logic        accept;
  logic        final_byte;
  logic [31:0] fcnt_inc;
  logic [31:0] clen_shift;
  logic [33:0] chunk_end;
  logic        misfit;
  logic [31:0] crc_next;
  logic [31:0] crc_out;
  logic [7:0]  crc_sel;
  logic [31:0] puts;
  cmd_t        cmd;

  assign accept     = in_valid_i && !q_full_i;
  assign final_byte = (pos_q + 32'd1) == input_length_i;
  assign fcnt_inc   = fcnt_q + 32'd1;
  assign clen_shift = {clen_q[23:0], in_byte_i};
  assign crc_next   = crc_byte(crc_q, in_byte_i);
  assign crc_out    = ~crc_q;
  // chunk starts three bytes before the last length byte
  assign chunk_end  = {2'b00, pos_q} + (CHUNK_OVERHEAD - 34'd3) + {2'b00, clen_shift};
  assign misfit     = (chunk_end > {2'b00, input_length_i}) ||
                      (chunk_end > {2'b00, output_limit_i});

  always_comb begin
    case (fcnt_q[1:0])
      2'd0:    crc_sel = crc_out[31:24];
      2'd1:    crc_sel = crc_out[23:16];
      2'd2:    crc_sel = crc_out[15:8];
      default: crc_sel = crc_out[7:0];
    endcase
  end

  always_comb begin
    pos_d   = pos_q + 32'd1;
    phase_d = phase_q;
    mode_d  = mode_q;
    clen_d  = clen_q;
    fcnt_d  = fcnt_q;
    crc_d   = crc_q;
    twin_d  = twin_q;
    puts    = 32'd0;
    cmd     = '0;

    if (pos_q == 32'd0 && (input_length_i < MIN_FILE_LEN || output_limit_i < MIN_FILE_LEN)) begin
      mode_d = MODE_PASS;
    end
    if (mode_d == MODE_REWRITE && phase_q == PH_SIG && in_byte_i != sig_byte(fcnt_q[2:0])) begin
      mode_d = MODE_PASS;
    end

    if (mode_d == MODE_PASS) begin
      cmd.has_byte = 1'b1;
      cmd.data     = {24'd0, in_byte_i};
      puts         = 32'd1;
    end else begin
      case (phase_q)
        PH_SIG: begin
          cmd.has_byte = 1'b1;
          cmd.data     = {24'd0, in_byte_i};
          puts         = 32'd1;
          fcnt_d       = fcnt_inc;
          if (fcnt_inc >= SIG_LEN) begin
            fcnt_d  = 32'd0;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          clen_d = clen_shift;
          fcnt_d = fcnt_inc;
          if (fcnt_inc >= FIELD_LEN) begin
            fcnt_d = 32'd0;
            if (misfit) begin
              phase_d = PH_STOP;
            end else begin
              cmd.has_len = 1'b1;
              cmd.data    = clen_shift;
              puts        = 32'd4;
              crc_d       = CRC_INIT;
              twin_d      = 32'd0;
              phase_d     = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          cmd.has_byte = 1'b1;
          cmd.data     = {24'd0, in_byte_i};
          puts         = 32'd1;
          crc_d        = crc_next;
          twin_d       = {twin_q[23:0], in_byte_i};
          fcnt_d       = fcnt_inc;
          if (fcnt_inc >= FIELD_LEN) begin
            fcnt_d  = 32'd0;
            phase_d = (clen_q == 32'd0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          cmd.has_byte = 1'b1;
          cmd.data     = {24'd0, in_byte_i};
          puts         = 32'd1;
          crc_d        = crc_next;
          fcnt_d       = fcnt_inc;
          if (fcnt_inc >= clen_q) begin
            fcnt_d  = 32'd0;
            phase_d = PH_CRC;
          end
        end
        PH_CRC: begin
          cmd.has_byte = 1'b1;
          cmd.data     = {24'd0, crc_sel};
          puts         = 32'd1;
          fcnt_d       = fcnt_inc;
          if (fcnt_inc >= FIELD_LEN) begin
            fcnt_d  = 32'd0;
            clen_d  = 32'd0;
            phase_d = (twin_q == IEND_WORD) ? PH_STOP : PH_LEN;
          end
        end
        default: begin
        end
      endcase
    end

    ecnt_d = ecnt_q + puts;

    if (final_byte) begin
      cmd.has_end = 1'b1;
      cmd.end_len = ecnt_d;
      cmd.rebuilt = (mode_d == MODE_REWRITE);
      // start the next file from a clean slate
      pos_d   = 32'd0;
      phase_d = PH_SIG;
      mode_d  = MODE_REWRITE;
      clen_d  = 32'd0;
      fcnt_d  = 32'd0;
      crc_d   = CRC_INIT;
      twin_d  = 32'd0;
      ecnt_d  = 32'd0;
    end
  end

  assign q_wr_o    = accept && (cmd.has_byte || cmd.has_len || cmd.has_end);
  assign q_wdata_o = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 32'd0;
      phase_q <= PH_SIG;
      mode_q  <= MODE_REWRITE;
      clen_q  <= 32'd0;
      fcnt_q  <= 32'd0;
      crc_q   <= CRC_INIT;
      twin_q  <= 32'd0;
      ecnt_q  <= 32'd0;
    end else if (accept) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      mode_q  <= mode_d;
      clen_q  <= clen_d;
      fcnt_q  <= fcnt_d;
      crc_q   <= crc_d;
      twin_q  <= twin_d;
      ecnt_q  <= ecnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SIG) |-> (fcnt_q < SIG_LEN))
    else $error("signature counter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEN || phase_q == PH_TYPE || phase_q == PH_CRC) |-> (fcnt_q < FIELD_LEN))
    else $error("field counter out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && final_byte) |=> (pos_q == 32'd0 && phase_q == PH_SIG))
    else $error("state not cleared after final byte");

endmodule

FILE: rtl/pngcrc_fifo.sv
module pngcrc_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  pngcrc_pkg::cmd_t  wdata_i,
  input  logic              rd_i,
  output pngcrc_pkg::cmd_t  head_o,
  output logic              empty_o,
  output logic              full_o
);
  import pngcrc_pkg::*;

  cmd_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QPTR_W+1)'(QDEPTH));
  assign head_o  = mem[rptr_q];

  always_comb begin
    count_d = count_q;
    if (wr_i && !rd_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_i && rd_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (rd_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_i |-> !full_o)
    else $error("write into full command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) rd_i |-> !empty_o)
    else $error("read from empty command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPTR_W+1)'(QDEPTH))
    else $error("command queue count overflow");

endmodule

FILE: rtl/pngcrc_back.sv
module pngcrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pngcrc_pkg::cmd_t  head_i,
  input  logic              q_empty_i,
  input  logic              pop_i,
  output logic              q_rd_o,
  output logic [7:0]        out_byte_o,
  output logic              end_marker_o,
  output logic [31:0]       out_length_o,
  output logic              was_rebuilt_o
);
  import pngcrc_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic [2:0] nbytes;
  logic [2:0] total;
  logic       last;
  logic       take;
  logic [7:0] len_sel;

  assign nbytes = head_i.has_len ? 3'd4 : (head_i.has_byte ? 3'd1 : 3'd0);
  assign total  = nbytes + {2'b00, head_i.has_end};
  assign last   = (idx_q == total - 3'd1);
  assign take   = pop_i && !q_empty_i;
  assign q_rd_o = take && last;

  always_comb begin
    case (idx_q[1:0])
      2'd0:    len_sel = head_i.data[31:24];
      2'd1:    len_sel = head_i.data[23:16];
      2'd2:    len_sel = head_i.data[15:8];
      default: len_sel = head_i.data[7:0];
    endcase
  end

  always_comb begin
    out_byte_o    = 8'd0;
    end_marker_o  = 1'b0;
    out_length_o  = 32'd0;
    was_rebuilt_o = 1'b0;
    if (idx_q < nbytes) begin
      out_byte_o = head_i.has_len ? len_sel : head_i.data[7:0];
    end else begin
      end_marker_o  = 1'b1;
      out_length_o  = head_i.end_len;
      was_rebuilt_o = head_i.rebuilt;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !q_empty_i |-> (idx_q < total))
    else $error("result index past end of command");

  assert property (@(posedge clk_i) disable iff (!rst_ni) (idx_q != 3'd0) |-> !q_empty_i)
    else $error("partial command lost from queue");

  // hold the result index while the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty_i && !pop_i) |=> $stable(idx_q))
    else $error("result index moved without a transaction");

endmodule

FILE: rtl/png_chunk_crc_rewriter.sv
// channel   direction  handshake          payload
// input     in         push / full        in_byte_i
// result    out        empty / pop        out_byte_o end_marker_o out_length_o was_rebuilt_o
// config    in         cfg_we_i           cfg_index_i cfg_wdata_i
//
// One byte is taken per cycle while the four-entry command queue has room.
// A byte gives zero to five results; the output side drains one per cycle while pop
// is high, so the last length byte of a chunk (four length bytes, perhaps an end marker)
// yields up to five results on the result port and the queue absorbs the burst.
// Reset is asynchronous and clears parser state, queue pointers and both registers.
// full rises when the queue holds four commands; pop low stalls the output side, and the input once the queue fills.
module png_chunk_crc_rewriter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        end_marker_o,
  output logic [31:0] out_length_o,
  output logic        was_rebuilt_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  import pngcrc_pkg::*;

  logic [31:0] input_length_q;
  logic [31:0] output_limit_q;
  logic        q_wr;
  logic        q_rd;
  cmd_t        q_wdata;
  cmd_t        q_head;
  logic        q_full;
  logic        q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_length_q <= 32'd0;
      output_limit_q <= 32'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_INPUT_LENGTH: input_length_q <= cfg_wdata_i;
        REG_OUTPUT_LIMIT: output_limit_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  pngcrc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (push),
    .in_byte_i      (in_byte_i),
    .input_length_i (input_length_q),
    .output_limit_i (output_limit_q),
    .q_full_i       (q_full),
    .q_wr_o         (q_wr),
    .q_wdata_o      (q_wdata)
  );

  pngcrc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .rd_i    (q_rd),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  pngcrc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (q_head),
    .q_empty_i     (q_empty),
    .pop_i         (pop),
    .q_rd_o        (q_rd),
    .out_byte_o    (out_byte_o),
    .end_marker_o  (end_marker_o),
    .out_length_o  (out_length_o),
    .was_rebuilt_o (was_rebuilt_o)
  );

  assign full  = q_full;
  assign empty = q_empty;

endmodule
